// File: sv/rx_ring_packet_dequeue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the receive ring dequeue block
// Shared property templates, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RX_RING_PACKET_DEQUEUE_ASSERT_SVH
`define RX_RING_PACKET_DEQUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RXPD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rxpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RXPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rxpd assertion failed");

`endif

// File: sv/rxpd_pkg.sv
// ----------------------------------------------------------------------------
// rxpd_pkg
// Types and constants shared by the receive ring dequeue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rxpd_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int HEADER_BYTES = 4;
    localparam int SPAN_W       = $clog2(255 * PAGE_BYTES + 1);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RING_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_STOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME  = 2'd3;

    typedef enum logic [1:0] {
        OUT_EMPTY     = 2'd0,
        OUT_BAD       = 2'd1,
        OUT_SIZE_ONLY = 2'd2,
        OUT_READ      = 2'd3
    } rxpd_outcome_t;

    typedef struct packed {
        logic [7:0]  ring_start_page;
        logic [7:0]  ring_stop_page;
        logic [15:0] min_frame_bytes;
        logic [15:0] max_frame_bytes;
    } rxpd_cfg_t;

    typedef struct packed {
        logic [7:0]  write_page;
        logic [7:0]  boundary_page;
        logic [7:0]  header_status;
        logic [7:0]  header_next_page;
        logic [15:0] header_byte_count;
        logic        buffer_present;
        logic [15:0] buffer_bytes;
    } rxpd_in_t;

    typedef struct packed {
        rxpd_outcome_t outcome;
        logic [15:0]   packet_bytes;
        logic [15:0]   first_address;
        logic [15:0]   first_length;
        logic [15:0]   second_address;
        logic [15:0]   second_length;
        logic          boundary_write;
        logic [7:0]    new_boundary;
    } rxpd_out_t;

    // Decode stage one: page resolved, size and boundary formed.
    typedef struct packed {
        logic [7:0]  page;
        logic [7:0]  write_page;
        logic [15:0] size;
        logic        status_ok;
        logic        buffer_present;
        logic [15:0] buffer_bytes;
        logic [7:0]  new_boundary;
    } rxpd_st1_t;

    // Decode stage two: outcome chosen, room and addresses formed.
    typedef struct packed {
        rxpd_outcome_t outcome;
        logic [15:0]   size;
        logic [15:0]   room;
        logic [15:0]   first_address;
        logic [15:0]   second_base;
        logic [7:0]    new_boundary;
    } rxpd_st2_t;

endpackage

`default_nettype wire

// File: sv/rxpd_cfg.sv
// ----------------------------------------------------------------------------
// rxpd_cfg
// Configuration register file with write-only access and reset defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rxpd_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [rxpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rxpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output rxpd_pkg::rxpd_cfg_t                   cfg
);
    import rxpd_pkg::*;

    rxpd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ring_start_page <= 8'd70;
            cfg_reg.ring_stop_page  <= 8'd128;
            cfg_reg.min_frame_bytes <= 16'd60;
            cfg_reg.max_frame_bytes <= 16'd1514;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RING_START: cfg_reg.ring_start_page <= cfg_wdata[7:0];
                REG_RING_STOP:  cfg_reg.ring_stop_page  <= cfg_wdata[7:0];
                REG_MIN_FRAME:  cfg_reg.min_frame_bytes <= cfg_wdata;
                REG_MAX_FRAME:  cfg_reg.max_frame_bytes <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/rxpd_decode.sv
// ----------------------------------------------------------------------------
// rxpd_decode
// First two pipeline stages: page wrap, size, outcome class and ring room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rxpd_decode (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rxpd_pkg::rxpd_cfg_t cfg,
    input  wire logic                i_valid,
    output logic                     i_ready,
    input  wire rxpd_pkg::rxpd_in_t  i_item,
    output logic                     o_valid,
    input  wire logic                o_ready,
    output rxpd_pkg::rxpd_st2_t      o_item
);
    import rxpd_pkg::*;

    logic      v1_reg;
    logic      v2_reg;
    rxpd_st1_t st1_reg;
    rxpd_st1_t st1_next;
    rxpd_st2_t st2_reg;
    rxpd_st2_t st2_next;
    logic      ready1;
    logic      ready2;

    logic [7:0]        page_inc;
    logic [7:0]        nb_dec;
    logic              empty;
    logic              bad;
    logic              short_buf;
    logic [7:0]        page_diff;
    logic [SPAN_W-1:0] span;

    assign ready2  = !v2_reg || o_ready;
    assign ready1  = !v1_reg || ready2;
    assign i_ready = ready1;

    always_comb begin
        page_inc = i_item.boundary_page + 8'd1;
        nb_dec   = i_item.header_next_page - 8'd1;
        st1_next.page = (page_inc == cfg.ring_stop_page) ? cfg.ring_start_page : page_inc;
        st1_next.write_page     = i_item.write_page;
        st1_next.size           = i_item.header_byte_count - 16'(HEADER_BYTES);
        st1_next.status_ok      = i_item.header_status[0];
        st1_next.buffer_present = i_item.buffer_present;
        st1_next.buffer_bytes   = i_item.buffer_bytes;
        st1_next.new_boundary   = (nb_dec < cfg.ring_start_page) ?
                                  (cfg.ring_stop_page - 8'd1) : nb_dec;
    end

    always_comb begin
        empty = (st1_reg.page == st1_reg.write_page);
        bad   = (st1_reg.size < cfg.min_frame_bytes) ||
                (st1_reg.size > cfg.max_frame_bytes) || !st1_reg.status_ok;
        short_buf = !st1_reg.buffer_present || (st1_reg.buffer_bytes < st1_reg.size);

        priority if (empty) begin
            st2_next.outcome = OUT_EMPTY;
        end else if (bad) begin
            st2_next.outcome = OUT_BAD;
        end else if (short_buf) begin
            st2_next.outcome = OUT_SIZE_ONLY;
        end else begin
            st2_next.outcome = OUT_READ;
        end

        page_diff = cfg.ring_stop_page - st1_reg.page;
        span      = SPAN_W'(page_diff) * SPAN_W'(PAGE_BYTES);
        if ((cfg.ring_stop_page > st1_reg.page) && (span > SPAN_W'(HEADER_BYTES))) begin
            st2_next.room = 16'(span - SPAN_W'(HEADER_BYTES));
        end else begin
            st2_next.room = 16'd0;
        end

        st2_next.size          = st1_reg.size;
        st2_next.first_address = 16'(16'(st1_reg.page) * 16'(PAGE_BYTES)) +
                                 16'(HEADER_BYTES);
        st2_next.second_base   = 16'(16'(cfg.ring_start_page) * 16'(PAGE_BYTES));
        st2_next.new_boundary  = st1_reg.new_boundary;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= i_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && i_valid) begin
            st1_reg <= st1_next;
        end
        if (ready2 && v1_reg) begin
            st2_reg <= st2_next;
        end
    end

    assign o_valid = v2_reg;
    assign o_item  = st2_reg;

endmodule

`default_nettype wire

// File: sv/rxpd_segment.sv
// ----------------------------------------------------------------------------
// rxpd_segment
// Final pipeline stage: splits the read at the ring end and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rxpd_segment (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                i_valid,
    output logic                     i_ready,
    input  wire rxpd_pkg::rxpd_st2_t i_item,
    output logic                     o_valid,
    input  wire logic                o_ready,
    output rxpd_pkg::rxpd_out_t      o_item
);
    import rxpd_pkg::*;

    logic      v3_reg;
    rxpd_out_t out_reg;
    rxpd_out_t out_next;
    logic      ready3;
    logic      wraps;

    assign ready3  = !v3_reg || o_ready;
    assign i_ready = ready3;

    always_comb begin
        wraps    = (i_item.size > i_item.room);
        out_next = '0;
        out_next.outcome = i_item.outcome;
        if (i_item.outcome != OUT_EMPTY) begin
            out_next.packet_bytes = i_item.size;
        end
        if (i_item.outcome == OUT_READ) begin
            out_next.first_address  = i_item.first_address;
            out_next.boundary_write = 1'b1;
            out_next.new_boundary   = i_item.new_boundary;
            if (wraps) begin
                out_next.first_length   = i_item.room;
                out_next.second_length  = i_item.size - i_item.room;
                out_next.second_address = i_item.second_base;
            end else begin
                out_next.first_length = i_item.size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ready3) begin
            v3_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && i_valid) begin
            out_reg <= out_next;
        end
    end

    assign o_valid = v3_reg;
    assign o_item  = out_reg;

endmodule

`default_nettype wire

// File: sv/rx_ring_packet_dequeue.sv
// ----------------------------------------------------------------------------
// rx_ring_packet_dequeue
// Decides one dequeue from a paged receive ring per item: empty, bad packet,
// size only, or a one- or two-segment read with a new boundary page.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Direction  Contents
//  input     s_valid, s_ready, s_item      in         ring pointers, header, buffer
//  result    m_valid, m_ready, m_item      out        outcome, segments, boundary
//  config    cfg_we, cfg_index, cfg_wdata  in         ring pages, frame size limits
//
//  An accepted item passes through three pipeline registers to its result on m_item.
//  One item is accepted per cycle while the pipeline is not stalled.
//  Each stage advances when it is empty or the stage after it moves on, so a
//  low m_ready stalls the pipeline back to s_ready without losing an item.
//  Reset is synchronous; it clears the stage valid bits and loads the register
//  defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_packet_dequeue (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire rxpd_pkg::rxpd_in_t               s_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output rxpd_pkg::rxpd_out_t                   m_item,
    input  wire logic                             cfg_we,
    input  wire logic [rxpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rxpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rxpd_pkg::*;

`include "rx_ring_packet_dequeue_assert.svh"

    rxpd_cfg_t cfg;
    rxpd_st2_t dec_item;
    logic      dec_valid;
    logic      dec_ready;

    rxpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rxpd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .i_valid (s_valid),
        .i_ready (s_ready),
        .i_item  (s_item),
        .o_valid (dec_valid),
        .o_ready (dec_ready),
        .o_item  (dec_item)
    );

    rxpd_segment u_segment (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (dec_valid),
        .i_ready (dec_ready),
        .i_item  (dec_item),
        .o_valid (m_valid),
        .o_ready (m_ready),
        .o_item  (m_item)
    );

    // An empty ring reports nothing beyond its outcome.
    `RXPD_ASSERT_SAME(a_empty_zero, aclk, aresetn,
        m_valid && (m_item.outcome == OUT_EMPTY),
        (m_item.packet_bytes == 16'd0) && (m_item.first_length == 16'd0) &&
        !m_item.boundary_write)
    // Only a packet that is read moves the boundary.
    `RXPD_ASSERT_SAME(a_bnd_only_read, aclk, aresetn,
        m_valid && (m_item.outcome != OUT_READ),
        !m_item.boundary_write && (m_item.second_length == 16'd0))
    // The two segments together cover the whole payload.
    `RXPD_ASSERT_SAME(a_seg_sum, aclk, aresetn,
        m_valid && (m_item.outcome == OUT_READ),
        (17'(m_item.first_length) + 17'(m_item.second_length)) ==
        17'(m_item.packet_bytes))
    // A stalled decode output keeps the final stage full.
    `RXPD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, dec_valid && !dec_ready, m_valid)

endmodule

`default_nettype wire

// File: bench/rx_ring_packet_dequeue_test.sv
// ----------------------------------------------------------------------------
// rx_ring_packet_dequeue_test
// Self-checking bench for the receive ring dequeue block. Directed descriptors
// cover empty rings, bad packets, size-only results and one- and two-segment
// reads. Random traffic then runs under several ring settings and idle
// patterns. Each result is checked field by field against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rx_ring_packet_dequeue_test;

    import rxpd_pkg::*;

    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 140;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rxpd_in_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rxpd_out_t             m_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_RING_START;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rxpd_cfg_t ring_cfg = '{ring_start_page: 8'd70, ring_stop_page: 8'd128,
                            min_frame_bytes: 16'd60, max_frame_bytes: 16'd1514};

    rxpd_out_t pending_decisions[$];
    rxpd_out_t oldest_decision;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    rx_ring_packet_dequeue DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_decisions.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic rxpd_out_t predict_dequeue(input rxpd_in_t d);
        rxpd_out_t   r;
        logic [7:0]  page;
        logic [15:0] size;
        logic [7:0]  nb;
        int          room;
        int          page_i;
        int          stop_i;
        int          start_i;
        r = '0;
        start_i = ring_cfg.ring_start_page;
        stop_i  = ring_cfg.ring_stop_page;
        page = d.boundary_page + 8'd1;
        if (page == ring_cfg.ring_stop_page) begin
            page = ring_cfg.ring_start_page;
        end
        page_i = page;
        if (page == d.write_page) begin
            r.outcome = OUT_EMPTY;
            return r;
        end
        size = d.header_byte_count - 16'(HEADER_BYTES);
        r.packet_bytes = size;
        if (size < ring_cfg.min_frame_bytes || size > ring_cfg.max_frame_bytes ||
            !d.header_status[0]) begin
            r.outcome = OUT_BAD;
            return r;
        end
        if (!d.buffer_present || d.buffer_bytes < size) begin
            r.outcome = OUT_SIZE_ONLY;
            return r;
        end
        room = 0;
        if (stop_i > page_i) begin
            room = (stop_i - page_i) * PAGE_BYTES - HEADER_BYTES;
        end
        if (int'(size) > room) begin
            r.first_length   = 16'(room);
            r.second_length  = 16'(int'(size) - room);
            r.second_address = 16'(start_i * PAGE_BYTES);
        end else begin
            r.first_length = size;
        end
        nb = d.header_next_page - 8'd1;
        if (nb < ring_cfg.ring_start_page) begin
            nb = ring_cfg.ring_stop_page - 8'd1;
        end
        r.outcome        = OUT_READ;
        r.first_address  = 16'(page_i * PAGE_BYTES + HEADER_BYTES);
        r.boundary_write = 1'b1;
        r.new_boundary   = nb;
        return r;
    endfunction

    function automatic rxpd_in_t descriptor(input int wr, input int bnd, input int st,
                                            input int hn, input int cnt, input int bp,
                                            input int bb);
        rxpd_in_t d;
        d.write_page        = wr[7:0];
        d.boundary_page     = bnd[7:0];
        d.header_status     = st[7:0];
        d.header_next_page  = hn[7:0];
        d.header_byte_count = cnt[15:0];
        d.buffer_present    = bp[0];
        d.buffer_bytes      = bb[15:0];
        return d;
    endfunction

    function automatic rxpd_in_t random_descriptor();
        rxpd_in_t d;
        int       start_i;
        int       stop_i;
        int       page_i;
        int       size_i;
        start_i = ring_cfg.ring_start_page;
        stop_i  = ring_cfg.ring_stop_page;
        d = descriptor($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom);
        if ($urandom_range(99) < 20) begin
            return d;
        end
        if (stop_i > start_i) begin
            page_i = $urandom_range(stop_i - 1, start_i);
            d.boundary_page = 8'(page_i - 1);
            if (page_i == start_i && $urandom_range(1) == 1) begin
                d.boundary_page = 8'(stop_i - 1);
            end
            d.header_next_page = 8'($urandom_range(stop_i, start_i));
        end else begin
            page_i = (int'(d.boundary_page) + 1) & 255;
            if (page_i == stop_i) begin
                page_i = start_i;
            end
        end
        if ($urandom_range(99) < 10) begin
            d.write_page = 8'(page_i);
        end
        d.header_status[0] = ($urandom_range(99) < 90);
        if (ring_cfg.min_frame_bytes <= ring_cfg.max_frame_bytes &&
            $urandom_range(99) < 85) begin
            size_i = $urandom_range(ring_cfg.max_frame_bytes, ring_cfg.min_frame_bytes);
        end else begin
            size_i = $urandom_range(65535, 0);
        end
        d.header_byte_count = 16'(size_i + HEADER_BYTES);
        d.buffer_present = ($urandom_range(99) < 90);
        if ($urandom_range(99) < 80) begin
            d.buffer_bytes = 16'($urandom_range(65535, size_i));
        end
        return d;
    endfunction

    task automatic offer_descriptor(input rxpd_in_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= d;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_decisions.push_back(predict_dequeue(d));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_decisions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_ring_config(input rxpd_cfg_t c);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_RING_START;
        cfg_wdata <= CFG_DATA_W'(c.ring_start_page);
        @(posedge aclk);
        cfg_index <= REG_RING_STOP;
        cfg_wdata <= CFG_DATA_W'(c.ring_stop_page);
        @(posedge aclk);
        cfg_index <= REG_MIN_FRAME;
        cfg_wdata <= c.min_frame_bytes;
        @(posedge aclk);
        cfg_index <= REG_MAX_FRAME;
        cfg_wdata <= c.max_frame_bytes;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ring_cfg = c;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_item);
                mismatch_count++;
            end else begin
                oldest_decision = pending_decisions.pop_front();
                check_field("outcome", oldest_decision.outcome, m_item.outcome);
                check_field("packet_bytes", oldest_decision.packet_bytes,
                            m_item.packet_bytes);
                check_field("first_address", oldest_decision.first_address,
                            m_item.first_address);
                check_field("first_length", oldest_decision.first_length,
                            m_item.first_length);
                check_field("second_address", oldest_decision.second_address,
                            m_item.second_address);
                check_field("second_length", oldest_decision.second_length,
                            m_item.second_length);
                check_field("boundary_write", oldest_decision.boundary_write,
                            m_item.boundary_write);
                check_field("new_boundary", oldest_decision.new_boundary,
                            m_item.new_boundary);
            end
        end
    end

    // The directed tests below start from the reset ring settings.
    task automatic test_empty_ring();
        offer_descriptor(descriptor(70, 69, 1, 80, 104, 1, 2000));
        offer_descriptor(descriptor(70, 127, 1, 80, 104, 1, 2000));
    endtask

    task automatic test_bad_packet();
        offer_descriptor(descriptor(100, 80, 1, 90, 3, 1, 65535));
        offer_descriptor(descriptor(100, 80, 1, 90, 63, 1, 65535));
        offer_descriptor(descriptor(100, 80, 1, 90, 1519, 1, 65535));
        offer_descriptor(descriptor(100, 80, 0, 90, 504, 1, 65535));
        offer_descriptor(descriptor(100, 80, 8'hFE, 90, 504, 1, 65535));
    endtask

    task automatic test_size_only();
        offer_descriptor(descriptor(100, 80, 1, 90, 504, 0, 65535));
        offer_descriptor(descriptor(100, 80, 1, 90, 504, 1, 499));
    endtask

    task automatic test_packet_read();
        offer_descriptor(descriptor(100, 80, 1, 90, 104, 1, 65535));
        offer_descriptor(descriptor(100, 80, 8'hFF, 90, 1518, 1, 1514));
        offer_descriptor(descriptor(100, 126, 1, 75, 1004, 1, 2000));
        offer_descriptor(descriptor(100, 200, 1, 75, 504, 1, 2000));
        offer_descriptor(descriptor(100, 255, 1, 75, 504, 1, 2000));
        offer_descriptor(descriptor(100, 80, 1, 70, 504, 1, 2000));
        offer_descriptor(descriptor(100, 80, 1, 0, 504, 1, 2000));
    endtask

    task automatic test_register_extremes();
        load_ring_config('{ring_start_page: 8'd0, ring_stop_page: 8'd255,
                           min_frame_bytes: 16'd0, max_frame_bytes: 16'hFFFF});
        offer_descriptor(descriptor(10, 20, 1, 30, 0, 1, 65535));
        offer_descriptor(descriptor(255, 254, 255, 255, 65535, 1, 65535));
        offer_descriptor(descriptor(0, 254, 1, 30, 100, 1, 65535));
        load_ring_config('{ring_start_page: 8'd0, ring_stop_page: 8'd1,
                           min_frame_bytes: 16'd0, max_frame_bytes: 16'd0});
        offer_descriptor(descriptor(5, 255, 1, 0, 4, 1, 0));
        offer_descriptor(descriptor(5, 0, 1, 1, 5, 1, 100));
        load_ring_config('{ring_start_page: 8'd255, ring_stop_page: 8'd255,
                           min_frame_bytes: 16'hFFFF, max_frame_bytes: 16'hFFFF});
        offer_descriptor(descriptor(0, 254, 1, 3, 3, 1, 65535));
    endtask

    task automatic test_random_traffic();
        rxpd_cfg_t c;
        int        phase;
        int        n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: c = '{8'd70, 8'd128, 16'd60, 16'd1514};
                1: c = '{8'd0, 8'd255, 16'd0, 16'hFFFF};
                2: c = '{8'd0, 8'd1, 16'd0, 16'hFFFF};
                3: c = '{8'd255, 8'd255, 16'd0, 16'hFFFF};
                default: begin
                    c.ring_start_page = 8'($urandom_range(254, 0));
                    c.ring_stop_page  = 8'($urandom_range(255, c.ring_start_page + 1));
                    c.min_frame_bytes = 16'($urandom_range(1600, 0));
                    c.max_frame_bytes = 16'(c.min_frame_bytes + $urandom_range(2000, 0));
                    if (phase == RANDOM_PHASES - 1) begin
                        c.ring_start_page = 8'($urandom_range(255, 130));
                        c.ring_stop_page  = 8'($urandom_range(120, 1));
                    end
                end
            endcase
            load_ring_config(c);
            set_idling(phase % 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_descriptor(random_descriptor());
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_ring();
        test_bad_packet();
        test_size_only();
        test_packet_read();
        test_register_extremes();
        test_random_traffic();
        set_idling(0);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
